### sv/sme_pkg.sv
// shared types and constants of the stack machine executor
package sme_pkg;

	typedef enum logic [4:0] {
		OP_OR     = 5'd0,
		OP_AND    = 5'd1,
		OP_LE     = 5'd2,
		OP_LT     = 5'd3,
		OP_GE     = 5'd4,
		OP_GT     = 5'd5,
		OP_NE     = 5'd6,
		OP_EQ     = 5'd7,
		OP_BOR    = 5'd8,
		OP_BAND   = 5'd9,
		OP_BXOR   = 5'd10,
		OP_SHL    = 5'd11,
		OP_SHR    = 5'd12,
		OP_ADD    = 5'd13,
		OP_MUL    = 5'd14,
		OP_SUB    = 5'd15,
		OP_DIV    = 5'd16,
		OP_MOD    = 5'd17,
		OP_LNOT   = 5'd18,
		OP_BNOT   = 5'd19,
		OP_NEG    = 5'd20,
		OP_BRF    = 5'd21,
		OP_JMP    = 5'd22,
		OP_PARAM  = 5'd23,
		OP_CALL   = 5'd24,
		OP_RET    = 5'd25,
		OP_PUSH   = 5'd26,
		OP_OPND   = 5'd27,
		OP_PRUNE  = 5'd28,
		OP_CLEAR  = 5'd29
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIV0  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_RD2,
		S_EX,
		S_ITER,
		S_CALL2
	} state_t;

	typedef enum logic [1:0] {
		MD_MUL,
		MD_DIV,
		MD_MOD
	} md_kind_t;

	typedef struct packed {
		logic     start;
		md_kind_t kind;
	} md_req_t;

endpackage

### sv/sme_muldiv.sv
// bit-serial multiplier and signed divider shared by times, divide and modulo
module sme_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  sme_pkg::md_req_t req,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	output logic             done,
	output logic [63:0]      result
);
	import sme_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	md_kind_t    kind_q;
	logic        neg_q;
	logic [63:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [64:0] sh;
	logic        ge;

	assign sh = {acc_q, x_q[63]};
	assign ge = sh >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			kind_q <= req.kind;
			acc_q  <= '0;
			if (req.kind == MD_MUL) begin
				x_q   <= a;
				y_q   <= b;
				neg_q <= 1'b0;
			end else begin
				x_q   <= a[63] ? 64'd0 - a : a;
				y_q   <= b[63] ? 64'd0 - b : b;
				neg_q <= (req.kind == MD_DIV) ? (a[63] ^ b[63]) : a[63];
			end
		end else if (busy_q) begin
			if (kind_q == MD_MUL) begin
				if (y_q[0])
					acc_q <= acc_q + x_q;
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[63:1]};
			end else begin
				if (ge) begin
					acc_q <= 64'(sh - {1'b0, y_q});
					x_q   <= {x_q[62:0], 1'b1};
				end else begin
					acc_q <= sh[63:0];
					x_q   <= {x_q[62:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		case (kind_q)
			MD_MUL:  result = acc_q;
			MD_DIV:  result = neg_q ? 64'd0 - x_q : x_q;
			default: result = neg_q ? 64'd0 - acc_q : acc_q;
		endcase
	end

	assign done = done_q;

endmodule

### sv/stack_machine_executor_unit.sv
// top level of the stack machine executor: decode, stack memory and sequencing
//
// usage: drive op, imm, pc, arg_count and operand_value and raise start while
// busy is low; the word is taken at that clock edge. exactly one result word
// follows: next_pc, top_value, stack_count, prune_mark and status are valid
// for the single cycle in which done is high, and the receiver cannot stall.
// the stack lives in a single-port-write, registered-read memory; the top of
// stack is kept in a register so most ops need at most one memory read.
// pushes, jumps, unary ops, clear and refused items end in the decode state;
// binary ops, branch and param go on to the execute state, call to a second
// write state, and return reads two words first. times, divide and modulo
// run one bit a cycle through the shared serial unit. busy stays high until
// the result is out, and a new word may be taken in the cycle that done is high.
// reset clears the stack pointer and frame base; the stack memory itself is
// not cleared, as only written entries are ever read.
module stack_machine_executor_unit #(
	parameter int STACK_DEPTH = 256,
	parameter int PROG_DEPTH  = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [4:0]                           op,
	input  logic signed [63:0]                   imm,
	input  logic [11:0]                          pc,
	input  logic [7:0]                           arg_count,
	input  logic signed [63:0]                   operand_value,
	output logic                                 done,
	output logic [11:0]                          next_pc,
	output logic signed [63:0]                   top_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]     stack_count,
	output logic                                 prune_mark,
	output logic [1:0]                           status
);
	import sme_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH + 1);
	localparam logic [SW:0] DEPTH_W = (SW+1)'(STACK_DEPTH);
	localparam logic [63:0] PC_MASK = 64'(PROG_DEPTH - 1) & 64'hFFF;

	state_t      state_q, state_d;
	logic [SW-1:0] sp_q, sp_d;
	logic [63:0] fb_q, fb_d;
	logic [63:0] tos_q, tos_d;
	logic [63:0] pcw_q, pcw_d;

	logic [4:0]  op_q;
	logic [63:0] imm_q;
	logic [11:0] pc_q;
	logic [7:0]  argc_q;
	logic [63:0] opv_q;

	logic [63:0] mem [STACK_DEPTH];
	logic [63:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [63:0] wdata;
	logic        we;

	logic        fin;
	logic [11:0] npc_d;
	logic        mark_d;
	logic [1:0]  st_d;

	logic        done_q;
	logic [11:0] next_pc_q;
	logic [63:0] top_q;
	logic [SW-1:0] count_q;
	logic        mark_q;
	logic [1:0]  status_q;

	md_req_t     md_req;
	logic        md_done;
	logic [63:0] md_res;

	op_t         opc;
	logic        is_bin;
	logic [63:0] sp64;
	logic [63:0] idx;
	logic [1:0]  err;
	logic [63:0] alu_r;
	logic        div0;
	logic [SW-1:0] ret_k;

	function automatic logic [11:0] wrap_pc(input logic [63:0] v);
		logic [63:0] m;
		m = v & PC_MASK;
		return m[11:0];
	endfunction

	assign opc    = op_t'(op_q);
	assign is_bin = op_q <= 5'(OP_MOD);
	assign sp64   = 64'(sp_q);
	assign idx    = fb_q + imm_q;
	assign div0   = (tos_q == 64'd0) && (opc == OP_DIV || opc == OP_MOD);
	assign ret_k  = SW'(imm_q);

	always_comb begin
		err = ST_OK;
		if (is_bin) begin
			if (sp_q < SW'(2))
				err = ST_UNDER;
		end else begin
			case (opc)
				OP_LNOT, OP_BNOT, OP_NEG, OP_BRF: begin
					if (sp_q == '0)
						err = ST_UNDER;
				end
				OP_PARAM: begin
					if ({1'b0, sp_q} >= DEPTH_W)
						err = ST_OVER;
					else if (idx >= sp64)
						err = ST_UNDER;
				end
				OP_CALL: begin
					if ({1'b0, sp_q} + (SW+1)'(2) > DEPTH_W)
						err = ST_OVER;
					else if (64'(argc_q) > sp64)
						err = ST_UNDER;
				end
				OP_RET: begin
					if (sp_q < SW'(3) || imm_q > sp64 - 64'd3)
						err = ST_UNDER;
				end
				OP_PUSH, OP_OPND, OP_PRUNE: begin
					if ({1'b0, sp_q} >= DEPTH_W)
						err = ST_OVER;
				end
				default: err = ST_OK;
			endcase
		end
	end

	always_comb begin
		logic [63:0] a, b;
		a = rdata_q;
		b = tos_q;
		case (opc)
			OP_OR:   alu_r = 64'(a != 0 || b != 0);
			OP_AND:  alu_r = 64'(a != 0 && b != 0);
			OP_LE:   alu_r = 64'(!($signed(b) < $signed(a)));
			OP_LT:   alu_r = 64'($signed(a) < $signed(b));
			OP_GE:   alu_r = 64'(!($signed(a) < $signed(b)));
			OP_GT:   alu_r = 64'($signed(b) < $signed(a));
			OP_NE:   alu_r = 64'(a != b);
			OP_EQ:   alu_r = 64'(a == b);
			OP_BOR:  alu_r = a | b;
			OP_BAND: alu_r = a & b;
			OP_BXOR: alu_r = a ^ b;
			OP_SHL:  alu_r = (b >= 64'd64) ? 64'd0 : (a << b[5:0]);
			OP_SHR:  alu_r = (b >= 64'd64) ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
			OP_ADD:  alu_r = a + b;
			OP_SUB:  alu_r = a - b;
			default: alu_r = 64'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		sp_d    = sp_q;
		fb_d    = fb_q;
		tos_d   = tos_q;
		pcw_d   = pcw_q;
		we      = 1'b0;
		waddr   = AW'(sp_q);
		wdata   = 64'd0;
		raddr   = AW'(sp_q - SW'(2));
		fin     = 1'b0;
		npc_d   = pc_q;
		mark_d  = 1'b0;
		st_d    = ST_OK;
		md_req.start = 1'b0;
		md_req.kind  = (opc == OP_MUL) ? MD_MUL : ((opc == OP_DIV) ? MD_DIV : MD_MOD);
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_DEC;
			end
			S_DEC: begin
				if (opc == OP_PARAM)
					raddr = idx[AW-1:0];
				else if (opc == OP_RET)
					raddr = AW'(sp_q - SW'(3));
				if (err != ST_OK) begin
					st_d    = err;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (is_bin || opc == OP_BRF || opc == OP_PARAM) begin
					state_d = S_EX;
				end else begin
					case (opc)
						OP_LNOT, OP_BNOT, OP_NEG: begin
							if (opc == OP_LNOT)
								tos_d = 64'(tos_q == 64'd0);
							else if (opc == OP_BNOT)
								tos_d = ~tos_q;
							else
								tos_d = 64'd0 - tos_q;
							we      = 1'b1;
							waddr   = AW'(sp_q - SW'(1));
							wdata   = tos_d;
							fin     = 1'b1;
							state_d = S_IDLE;
						end
						OP_JMP: begin
							npc_d   = wrap_pc(imm_q);
							fin     = 1'b1;
							state_d = S_IDLE;
						end
						OP_PUSH, OP_OPND, OP_PRUNE: begin
							if (opc == OP_PUSH)
								tos_d = imm_q;
							else if (opc == OP_OPND)
								tos_d = opv_q;
							else
								tos_d = 64'd0;
							mark_d  = (opc == OP_PRUNE);
							we      = 1'b1;
							wdata   = tos_d;
							sp_d    = sp_q + SW'(1);
							fin     = 1'b1;
							state_d = S_IDLE;
						end
						OP_CLEAR: begin
							sp_d    = '0;
							fb_d    = 64'd0;
							fin     = 1'b1;
							state_d = S_IDLE;
						end
						OP_CALL: begin
							we      = 1'b1;
							wdata   = 64'(pc_q);
							state_d = S_CALL2;
						end
						OP_RET: begin
							state_d = S_RD2;
						end
						default: begin
							fin     = 1'b1;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD2: begin
				raddr   = AW'(sp_q - SW'(2));
				pcw_d   = rdata_q;
				state_d = S_EX;
			end
			S_CALL2: begin
				we      = 1'b1;
				waddr   = AW'(sp_q + SW'(1));
				wdata   = fb_q;
				tos_d   = fb_q;
				sp_d    = sp_q + SW'(2);
				fb_d    = 64'(sp_q) - 64'(argc_q);
				npc_d   = wrap_pc(imm_q);
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_EX: begin
				if (is_bin) begin
					if (div0) begin
						we      = 1'b1;
						waddr   = AW'(sp_q - SW'(2));
						wdata   = 64'd0;
						tos_d   = 64'd0;
						sp_d    = sp_q - SW'(1);
						st_d    = ST_DIV0;
						fin     = 1'b1;
						state_d = S_IDLE;
					end else if (opc == OP_MUL || opc == OP_DIV || opc == OP_MOD) begin
						md_req.start = 1'b1;
						state_d      = S_ITER;
					end else begin
						we      = 1'b1;
						waddr   = AW'(sp_q - SW'(2));
						wdata   = alu_r;
						tos_d   = alu_r;
						sp_d    = sp_q - SW'(1);
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (opc == OP_BRF) begin
					if (tos_q == 64'd0)
						npc_d = wrap_pc(imm_q);
					tos_d   = rdata_q;
					sp_d    = sp_q - SW'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (opc == OP_PARAM) begin
					we      = 1'b1;
					wdata   = rdata_q;
					tos_d   = rdata_q;
					sp_d    = sp_q + SW'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					npc_d   = wrap_pc(pcw_q);
					fb_d    = rdata_q;
					we      = 1'b1;
					waddr   = AW'(sp_q - SW'(3) - ret_k);
					wdata   = tos_q;
					sp_d    = sp_q - SW'(2) - ret_k;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ITER: begin
				if (md_done) begin
					we      = 1'b1;
					waddr   = AW'(sp_q - SW'(2));
					wdata   = md_res;
					tos_d   = md_res;
					sp_d    = sp_q - SW'(1);
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			fb_q    <= 64'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			fb_q    <= fb_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		pcw_q <= pcw_d;
		if (state_q == S_IDLE && start) begin
			op_q   <= op;
			imm_q  <= imm;
			pc_q   <= pc;
			argc_q <= arg_count;
			opv_q  <= operand_value;
		end
		if (fin) begin
			next_pc_q <= npc_d;
			top_q     <= (sp_d != '0) ? tos_d : 64'd0;
			count_q   <= sp_d;
			mark_q    <= mark_d;
			status_q  <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	sme_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (rdata_q),
		.b      (tos_q),
		.done   (md_done),
		.result (md_res)
	);

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign next_pc     = next_pc_q;
	assign top_value   = top_q;
	assign stack_count = count_q;
	assign prune_mark  = mark_q;
	assign status      = status_q;

endmodule
